[src/tmps_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle minimum path sum: shared package
// Widths, limits and the saturating adder used by the path-sum core.
// ----------------------------------------------------------------------------
package tmps_pkg;

   localparam int ELEM_W           = 16;
   localparam int SUM_W            = 32;
   localparam int DEFAULT_MAX_ROWS = 256;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

   // Add an element to a path sum and clamp to the signed 32-bit range.
   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [ELEM_W-1:0] elem,
      input logic signed [SUM_W-1:0]  base
   );
      logic signed [SUM_W:0] wide;
      wide = (SUM_W+1)'(elem) + (SUM_W+1)'(base);
      if (wide[SUM_W] != wide[SUM_W-1]) begin
         sat_add = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : SUM_MAX;
      end else begin
         sat_add = wide[SUM_W-1:0];
      end
   endfunction

endpackage

[src/tmps_row_store.sv]
// ----------------------------------------------------------------------------
// Triangle minimum path sum: row store
// One row of path sums, one write and one registered read per cycle.
// A read of the address written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module tmps_row_store #(
   parameter int DEPTH  = tmps_pkg::DEFAULT_MAX_ROWS,
   parameter int ADDR_W = 8
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [ADDR_W-1:0]                   wr_addr,
   input  logic signed [tmps_pkg::SUM_W-1:0]   wr_data,
   input  logic [ADDR_W-1:0]                   rd_addr,
   output logic signed [tmps_pkg::SUM_W-1:0]   rd_data
);

   logic signed [tmps_pkg::SUM_W-1:0] mem [DEPTH];
   logic signed [tmps_pkg::SUM_W-1:0] rd_data_ff;

   // Write the new sum
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read with write-first bypass
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/triangle_min_path_sum_core.sv]
// ----------------------------------------------------------------------------
// Triangle minimum path sum: core
// Streams a number triangle in row order and reports its minimum path sum.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one triangle element per beat in row order; row r
//   holds r+1 elements. req_last_item marks the final element. Each accepted
//   beat updates the running row of path sums, so one beat is taken every
//   clock while req_stall is low. The row store is read at the next column
//   as the current one is written, keeping one element per cycle.
//   The beat with req_last_item produces one rsp beat, registered, in the
//   cycle after acceptance: rsp_min_total is the minimum path sum over the final
//   row, and rsp_malformed flags a triangle that ended mid-row or went past
//   MAX_ROWS rows (rsp_min_total is then zero). Other beats produce nothing.
//   Throughput is 1 element per cycle while req_stall is low.
//   While rsp_stall holds a pending result, req_stall is raised; otherwise a
//   new element is taken even as the result register empties.
//   Synchronous reset clears the row and column counters, the running
//   minimum and the result valid flag; the row store is not cleared.
//   After each final element the block is ready for a new triangle.
// ----------------------------------------------------------------------------
module triangle_min_path_sum_core #(
   parameter int MAX_ROWS = tmps_pkg::DEFAULT_MAX_ROWS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [tmps_pkg::ELEM_W-1:0]   req_elem_value,
   input  logic                                 req_last_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tmps_pkg::SUM_W-1:0]    rsp_min_total,
   output logic                                 rsp_malformed
);

   localparam int COL_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ROW_W = $clog2(MAX_ROWS + 1);
   localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(MAX_ROWS);

   logic [COL_W-1:0]                   column_index_ff, column_index_in;
   logic [ROW_W-1:0]                   row_index_ff, row_index_in;
   logic signed [tmps_pkg::SUM_W-1:0]  left_carry_ff, left_carry_in;
   logic signed [tmps_pkg::SUM_W-1:0]  row_minimum_ff, row_minimum_in;
   logic                               overflow_seen_ff, overflow_seen_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [tmps_pkg::SUM_W-1:0]  rsp_min_total_ff, rsp_min_total_in;
   logic                               rsp_malformed_ff, rsp_malformed_in;

   logic                               accept;
   logic                               in_range;
   logic [ROW_W-1:0]                   column_ext;
   logic                               has_above;
   logic                               has_left;
   logic                               row_done;
   logic                               bad;
   logic signed [tmps_pkg::SUM_W-1:0]  above_sum;
   logic signed [tmps_pkg::SUM_W-1:0]  best;
   logic signed [tmps_pkg::SUM_W-1:0]  addend;
   logic signed [tmps_pkg::SUM_W-1:0]  path_sum;
   logic signed [tmps_pkg::SUM_W-1:0]  row_min_new;
   logic                               store_wr_en;

   // Hold the input only while a finished result is blocked
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   tmps_row_store #(
      .DEPTH  (MAX_ROWS),
      .ADDR_W (COL_W)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (column_index_ff),
      .wr_data (path_sum),
      .rd_addr (column_index_in),
      .rd_data (above_sum)
   );

   // Best predecessor and the new path sum
   always_comb begin
      in_range   = row_index_ff < ROW_LIMIT;
      column_ext = ROW_W'(column_index_ff);
      has_above  = column_ext < row_index_ff;
      has_left   = column_index_ff != '0;
      row_done   = in_range && (column_ext == row_index_ff);
      if (has_above && !(has_left && (left_carry_ff < above_sum))) begin
         best = above_sum;
      end else begin
         best = left_carry_ff;
      end
      addend      = (row_index_ff == '0) ? '0 : best;
      path_sum    = tmps_pkg::sat_add(req_elem_value, addend);
      row_min_new = (!has_left || (path_sum < row_minimum_ff)) ? path_sum : row_minimum_ff;
      store_wr_en = accept && in_range;
      bad         = overflow_seen_ff || !row_done;
   end

   // Advance the stream state
   always_comb begin
      column_index_in  = column_index_ff;
      row_index_in     = row_index_ff;
      left_carry_in    = left_carry_ff;
      row_minimum_in   = row_minimum_ff;
      overflow_seen_in = overflow_seen_ff;
      if (accept) begin
         if (in_range) begin
            left_carry_in  = above_sum;
            row_minimum_in = row_min_new;
            if (row_done) begin
               column_index_in = '0;
               row_index_in    = row_index_ff + 1'b1;
            end else begin
               column_index_in = column_index_ff + 1'b1;
            end
         end else begin
            overflow_seen_in = 1'b1;
         end
         if (req_last_item) begin
            column_index_in  = '0;
            row_index_in     = '0;
            left_carry_in    = '0;
            row_minimum_in   = tmps_pkg::SUM_MAX;
            overflow_seen_in = 1'b0;
         end
      end
   end

   // Load or drop the result beat
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_min_total_in = rsp_min_total_ff;
      rsp_malformed_in = rsp_malformed_ff;
      if (accept && req_last_item) begin
         rsp_valid_in     = 1'b1;
         rsp_min_total_in = bad ? '0 : row_min_new;
         rsp_malformed_in = bad;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         column_index_ff  <= '0;
         row_index_ff     <= '0;
         left_carry_ff    <= '0;
         row_minimum_ff   <= tmps_pkg::SUM_MAX;
         overflow_seen_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         column_index_ff  <= column_index_in;
         row_index_ff     <= row_index_in;
         left_carry_ff    <= left_carry_in;
         row_minimum_ff   <= row_minimum_in;
         overflow_seen_ff <= overflow_seen_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_min_total_ff <= rsp_min_total_in;
      rsp_malformed_ff <= rsp_malformed_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_total = rsp_min_total_ff;
   assign rsp_malformed = rsp_malformed_ff;

`ifndef SYNTHESIS
   a_column_within_row: assert property (@(posedge clock) disable iff (reset)
      (row_index_ff < ROW_LIMIT) |-> (ROW_W'(column_index_ff) <= row_index_ff))
      else $error("column index ran past the current row");

   a_limit_column_zero: assert property (@(posedge clock) disable iff (reset)
      (row_index_ff == ROW_LIMIT) |-> (column_index_ff == '0))
      else $error("column index moved after the row limit");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_item) |=> (rsp_valid_ff && (row_index_ff == '0)
                                     && (column_index_ff == '0) && !overflow_seen_ff))
      else $error("final element did not produce a result and restart");

   a_malformed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_malformed_ff) |-> (rsp_min_total_ff == '0))
      else $error("malformed result carries a nonzero total");
`endif

endmodule

[sim/tb_triangle_min_path_sum_core.sv]
// ----------------------------------------------------------------------------
// Triangle minimum path sum: core testbench
// Streams small and broken triangles into the core with random gaps and
// back-pressure, predicts every path-sum result in a scoreboard and compares
// each rsp beat field by field.
// ----------------------------------------------------------------------------
module tb_triangle_min_path_sum_core;

   localparam int ROW_LIMIT    = tmps_pkg::DEFAULT_MAX_ROWS;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_CYCLES = 500000;

   typedef enum {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_EDGES} fill_mode_type;

   // Predicts the path-sum results and checks the rsp beats against them.
   class path_sum_scoreboard;
      localparam int ROWS = tmps_pkg::DEFAULT_MAX_ROWS;

      typedef struct packed {
         logic signed [tmps_pkg::SUM_W-1:0] min_total;
         logic                              malformed;
      } path_result_type;

      bit signed [tmps_pkg::SUM_W-1:0] row_store [ROWS];
      bit signed [tmps_pkg::SUM_W-1:0] left_hold;
      bit signed [tmps_pkg::SUM_W-1:0] row_min;
      bit [7:0]                        col_at;
      bit [8:0]                        row_at;
      bit                              past_limit;
      path_result_type                 expected[$];
      int                              errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         left_hold  = '0;
         col_at     = '0;
         row_at     = '0;
         row_min    = {1'b0, {(tmps_pkg::SUM_W-1){1'b1}}};
         past_limit = 1'b0;
      endfunction

      function bit signed [tmps_pkg::SUM_W-1:0] clamp_sum(
         logic signed [tmps_pkg::ELEM_W-1:0] v,
         bit signed [tmps_pkg::SUM_W-1:0]    b
      );
         longint s;
         s = longint'(v) + longint'(b);
         if (s > 64'sd2147483647) return 32'sh7FFF_FFFF;
         if (s < -64'sd2147483648) return 32'sh8000_0000;
         return s[31:0];
      endfunction

      // Update the row of best sums for one accepted element.
      function void note_element(logic signed [tmps_pkg::ELEM_W-1:0] v, logic last);
         bit signed [tmps_pkg::SUM_W-1:0] base, total;
         bit                              have, done;
         path_result_type                 r;
         done = 1'b0;
         if (row_at >= ROWS) begin
            past_limit = 1'b1;
         end else begin
            have = 1'b0;
            base = '0;
            if (col_at < row_at) begin
               base = row_store[col_at];
               have = 1'b1;
            end
            if (col_at > 0 && (!have || left_hold < base)) begin
               base = left_hold;
               have = 1'b1;
            end
            total = clamp_sum(v, base);
            left_hold = row_store[col_at];
            row_store[col_at] = total;
            if (col_at == 0 || total < row_min) row_min = total;
            if (col_at == row_at) begin
               col_at = '0;
               row_at = row_at + 9'd1;
               done   = 1'b1;
            end else begin
               col_at = col_at + 8'd1;
            end
         end
         if (last) begin
            r.malformed = past_limit || !done;
            r.min_total = r.malformed ? '0 : row_min;
            expected.push_back(r);
            restart();
         end
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask

      // Compare one rsp beat with the oldest prediction.
      task check_result(logic signed [tmps_pkg::SUM_W-1:0] total, logic bad);
         path_result_type want;
         if (expected.size() == 0) begin
            report_mismatch($sformatf("unexpected result min_total=%0d malformed=%0b",
                                      total, bad));
            return;
         end
         want = expected.pop_front();
         if (total !== want.min_total)
            report_mismatch($sformatf("min_total %0d, want %0d", total, want.min_total));
         if (bad !== want.malformed)
            report_mismatch($sformatf("malformed %0b, want %0b", bad, want.malformed));
      endtask
   endclass

   logic                               clock          = 1'b0;
   logic                               reset          = 1'b1;
   logic                               req_valid      = 1'b0;
   logic                               req_stall;
   logic signed [tmps_pkg::ELEM_W-1:0] req_elem_value = '0;
   logic                               req_last_item  = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall      = 1'b0;
   logic signed [tmps_pkg::SUM_W-1:0]  rsp_min_total;
   logic                               rsp_malformed;

   bit idle_on     = 1'b1;
   bit stall_on    = 1'b1;
   bit hold_req    = 1'b0;
   bit hold_active = 1'b0;

   path_sum_scoreboard sb = new();

   triangle_min_path_sum_core #(.MAX_ROWS(ROW_LIMIT)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_elem_value (req_elem_value),
      .req_last_item  (req_last_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_min_total  (rsp_min_total),
      .rsp_malformed  (rsp_malformed)
   );

   always #2 clock = ~clock;

   // Watch both channels at each edge: check results, then note elements.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_min_total, rsp_malformed);
         if (req_valid && !req_stall) sb.note_element(req_elem_value, req_last_item);
      end
   end

   function automatic logic signed [tmps_pkg::ELEM_W-1:0] pick_value(fill_mode_type mode);
      case (mode)
         FILL_MAX: return 16'sh7FFF;
         FILL_MIN: return 16'sh8000;
         FILL_EDGES: begin
            case ($urandom_range(0, 4))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sh0000;
               3: return 16'shFFFF;
               default: return 16'($urandom_range(0, 65535));
            endcase
         end
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Offer one beat, with an optional gap first; return once it is taken.
   task automatic send_elem(logic signed [tmps_pkg::ELEM_W-1:0] v, logic last);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_elem_value <= v;
      req_last_item  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   // Send count elements in row order; the last one closes the triangle.
   task automatic send_triangle(int count, fill_mode_type mode);
      for (int i = 0; i < count; i++) send_elem(pick_value(mode), i == count - 1);
   endtask

   // Receiver: random stall bursts, plus one long hold on request.
   initial begin : result_receiver
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req    = 1'b0;
            hold_active = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_active = 1'b0;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
      end
   end

   initial begin : stimulus
      int            rows, count, random_items;
      fill_mode_type mode;
      random_items = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single-element triangles, extremes, and early endings.
      send_triangle(1, FILL_MAX);
      send_triangle(1, FILL_MIN);
      send_triangle(3, FILL_EDGES);
      send_triangle(6, FILL_MIN);
      send_triangle(6, FILL_MAX);
      send_triangle(2, FILL_RANDOM);
      send_triangle(4, FILL_EDGES);

      // Hold off the receiver and keep offering beats until the input stalls.
      idle_on = 1'b0;
      drop_valid();
      hold_req = 1'b1;
      do @(posedge clock); while (!hold_active);
      for (int i = 0; i < 8; i++) send_elem(pick_value(FILL_RANDOM), 1'b1);
      idle_on = 1'b1;

      // Random triangles, mostly well formed and small, some cut short.
      while (random_items < 700) begin
         if (random_items >= 600) begin
            idle_on  = 1'b0;
            stall_on = 1'b0;
         end
         rows  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
         count = rows * (rows + 1) / 2;
         if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count);
         case ($urandom_range(0, 9))
            0:       mode = FILL_MAX;
            1:       mode = FILL_MIN;
            2, 3:    mode = FILL_EDGES;
            default: mode = FILL_RANDOM;
         endcase
         send_triangle(count, mode);
         random_items += count;
      end

      // Drain the outstanding results, then give the verdict.
      drop_valid();
      @(posedge clock);
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("triangle_min_path_sum_core test passed");
      end else begin
         $display("triangle_min_path_sum_core test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * 4);
      $display("triangle_min_path_sum_core test failed");
      $finish;
   end

endmodule
